### hdl/tlc_pkg.sv
// shared types and constants of the two-level write-back cache
package tlc_pkg;

  localparam int WORD_BYTES  = 4;
  localparam int BLOCK_BYTES = 64;
  localparam int L1_LINES    = 256;
  localparam int L2_SETS     = 512;
  localparam int L2_WAYS     = 2;
  localparam int MEM_BYTES   = 1048576;

  localparam int ADDR_W      = 20;
  localparam int WORD_W      = 32;
  localparam int COST_W      = 16;
  localparam int BW          = BLOCK_BYTES / WORD_BYTES;
  localparam int BLOCK_BITS  = BW * WORD_W;
  localparam int WORD_LSB    = $clog2(WORD_BYTES);
  localparam int BLK_LSB     = $clog2(BLOCK_BYTES);
  localparam int OFF_W       = BLK_LSB - WORD_LSB;
  localparam int BLK_W       = ADDR_W - BLK_LSB;
  localparam int L1_IDX_W    = $clog2(L1_LINES);
  localparam int L1_TAG_W    = BLK_W - L1_IDX_W;
  localparam int L1_ROW_W    = L1_TAG_W + BLOCK_BITS;
  localparam int L2_SET_W    = $clog2(L2_SETS);
  localparam int L2_TAG_W    = BLK_W - L2_SET_W;
  localparam int L2_WAY_W    = $clog2(L2_WAYS);
  localparam int L2_LINES    = L2_SETS * L2_WAYS;
  localparam int MEM_BLOCKS  = MEM_BYTES / BLOCK_BYTES;
  localparam int MEM_BLK_W   = $clog2(MEM_BLOCKS);
  localparam int CFG_COUNT   = 6;
  localparam int CFG_IDX_W   = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_L1_READ   = 3'd0,
    CFG_L1_WRITE  = 3'd1,
    CFG_L2_READ   = 3'd2,
    CFG_L2_WRITE  = 3'd3,
    CFG_MEM_READ  = 3'd4,
    CFG_MEM_WRITE = 3'd5
  } cfg_reg_t;

  localparam logic [COST_W-1:0] CFG_RESET [CFG_COUNT] = '{
    16'd1, 16'd1, 16'd10, 16'd10, 16'd100, 16'd100
  };

  // per-set L2 bookkeeping, both ways in one row
  typedef struct packed {
    logic                               victim;
    logic [L2_WAYS-1:0]                 valid;
    logic [L2_WAYS-1:0]                 dirty;
    logic [L2_WAYS-1:0][L2_TAG_W-1:0]   tag;
  } meta_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_L1_CHK,
    ST_L2_META,
    ST_L2_CHK,
    ST_VICT_RD,
    ST_VICT_WB,
    ST_MEM_RD,
    ST_FILL,
    ST_L2_OP,
    ST_L2_RDWAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic err_out;
    logic req_wb;
    logic req_fill;
    logic meta_rd;
    logic l2_chk;
    logic vict_rd;
    logic vict_wb;
    logic mem_rd;
    logic fill;
    logic l2_op;
    logic l2_rdwait;
    logic finish;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic range_err;
    logic l1_hit;
    logic l1_wb;
    logic l2_hit;
    logic vict_dirty;
    logic req_wr;
    logic clr_last;
  } status_t;

endpackage

### hdl/tlc_ctrl.sv
// sequencing state machine of the two-level cache
module tlc_ctrl import tlc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (status.range_err) begin
            cmd.err_out = 1'b1;
          end else begin
            state_next = ST_L1_CHK;
          end
        end
      end
      ST_L1_CHK: begin
        if (status.l1_hit) begin
          state_next = ST_FINISH;
        end else if (status.l1_wb) begin
          cmd.req_wb = 1'b1;
          state_next = ST_L2_META;
        end else begin
          cmd.req_fill = 1'b1;
          state_next   = ST_L2_META;
        end
      end
      ST_L2_META: begin
        cmd.meta_rd = 1'b1;
        state_next  = ST_L2_CHK;
      end
      ST_L2_CHK: begin
        cmd.l2_chk = 1'b1;
        if (status.l2_hit)          state_next = ST_L2_OP;
        else if (status.vict_dirty) state_next = ST_VICT_RD;
        else                        state_next = ST_MEM_RD;
      end
      ST_VICT_RD: begin
        cmd.vict_rd = 1'b1;
        state_next  = ST_VICT_WB;
      end
      ST_VICT_WB: begin
        cmd.vict_wb = 1'b1;
        state_next  = ST_MEM_RD;
      end
      ST_MEM_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_FILL;
      end
      ST_FILL: begin
        cmd.fill   = 1'b1;
        state_next = ST_L2_OP;
      end
      ST_L2_OP: begin
        cmd.l2_op = 1'b1;
        if (status.req_wr) begin
          cmd.req_fill = 1'b1;
          state_next   = ST_L2_META;
        end else begin
          state_next = ST_L2_RDWAIT;
        end
      end
      ST_L2_RDWAIT: begin
        cmd.l2_rdwait = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### hdl/tlc_dp.sv
// memories, block buffer, cost accumulator and result registers
module tlc_dp import tlc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 kind,
  input  logic [ADDR_W-1:0]    address,
  input  logic [WORD_W-1:0]    write_word,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COST_W-1:0]    cfg_data,
  input  cmd_t                 cmd,
  output status_t              status,
  output logic                 done,
  output logic [WORD_W-1:0]    read_word,
  output logic                 l1_hit,
  output logic                 l2_hit,
  output logic                 range_error,
  output logic [WORD_W-1:0]    elapsed_time
);

  // captured transaction
  logic                  op_wr;
  logic [BLK_W-1:0]      cur_blk;
  logic [OFF_W-1:0]      cur_off;
  logic [WORD_W-1:0]     wdata;
  logic [BLOCK_BITS-1:0] blk_buf;

  // storage
  logic [L1_ROW_W-1:0]   l1_mem   [L1_LINES];
  logic [L1_ROW_W-1:0]   l1_q;
  logic [L1_LINES-1:0]   l1_valid;
  logic [L1_LINES-1:0]   l1_dirty;
  meta_t                 meta_mem [L2_SETS];
  meta_t                 meta_q;
  meta_t                 meta_w;
  meta_t                 meta_nxt;
  logic [BLOCK_BITS-1:0] l2_mem   [L2_LINES];
  logic [BLOCK_BITS-1:0] l2_q;
  logic [BLOCK_BITS-1:0] back_mem [MEM_BLOCKS];
  logic [BLOCK_BITS-1:0] back_q;

  // current L2 request
  logic [BLK_W-1:0]      req_blk;
  logic                  req_wr;
  logic [L2_WAY_W-1:0]   way;
  logic                  l2hit_reg;
  logic                  l1hit_reg;

  logic [WORD_W-1:0]     time_total;
  logic [COST_W-1:0]     cfg_regs [CFG_COUNT];
  logic [MEM_BLK_W-1:0]  clr_cnt;

  // decode
  logic [L1_IDX_W-1:0]   cur_idx;
  logic [L1_TAG_W-1:0]   cur_tag;
  logic [L1_IDX_W-1:0]   in_idx;
  logic [L1_TAG_W-1:0]   l1q_tag;
  logic [L2_SET_W-1:0]   req_set;
  logic [L2_TAG_W-1:0]   req_tag;
  logic [WORD_W-1:0]     addr_end;
  logic [1:0]            way_hit;
  logic [L2_WAY_W-1:0]   way_sel;
  logic [COST_W-1:0]     cost_sel;
  logic [WORD_W-1:0]     time_sum;
  logic [BLOCK_BITS-1:0] new_buf;

  // set by every command except those of the L1 check and finish
  function automatic logic busy_any(input cmd_t c);
    busy_any = c.capture | c.err_out | c.meta_rd | c.l2_chk | c.vict_rd | c.vict_wb
             | c.mem_rd | c.fill | c.l2_op | c.l2_rdwait | c.clear;
  endfunction

  assign cur_idx  = cur_blk[L1_IDX_W-1:0];
  assign cur_tag  = cur_blk[BLK_W-1 -: L1_TAG_W];
  assign in_idx   = address[BLK_LSB +: L1_IDX_W];
  assign l1q_tag  = l1_q[L1_ROW_W-1 -: L1_TAG_W];
  assign req_set  = req_blk[L2_SET_W-1:0];
  assign req_tag  = req_blk[BLK_W-1 -: L2_TAG_W];
  assign addr_end = WORD_W'({address[ADDR_W-1:WORD_LSB], {WORD_LSB{1'b0}}})
                  + WORD_W'(WORD_BYTES);

  // L2 tag compare on the freshly read set row
  always_comb begin
    for (int w = 0; w < L2_WAYS; w++) begin
      way_hit[w] = meta_q.valid[w] && (meta_q.tag[w] == req_tag);
    end
    if (way_hit[0])      way_sel = 1'b0;
    else if (way_hit[1]) way_sel = 1'b1;
    else                 way_sel = meta_q.victim;
  end

  always_comb begin
    status.range_err  = (addr_end > WORD_W'(MEM_BYTES));
    status.l1_hit     = l1_valid[cur_idx] && (l1q_tag == cur_tag);
    status.l1_wb      = l1_valid[cur_idx] && l1_dirty[cur_idx];
    status.l2_hit     = |way_hit;
    status.vict_dirty = meta_q.valid[way_sel] && meta_q.dirty[way_sel];
    status.req_wr     = req_wr;
    status.clr_last   = &clr_cnt;
  end

  // set row after the access: other way becomes victim
  always_comb begin
    meta_nxt        = meta_w;
    meta_nxt.victim = ~way;
    if (req_wr) meta_nxt.dirty[way] = 1'b1;
  end

  // cost of the step being taken
  always_comb begin
    priority if (cmd.vict_wb) cost_sel = cfg_regs[CFG_MEM_WRITE];
    else if (cmd.fill)        cost_sel = cfg_regs[CFG_MEM_READ];
    else if (cmd.l2_op)       cost_sel = req_wr ? cfg_regs[CFG_L2_WRITE]
                                                : cfg_regs[CFG_L2_READ];
    else                      cost_sel = op_wr ? cfg_regs[CFG_L1_WRITE]
                                               : cfg_regs[CFG_L1_READ];
  end
  assign time_sum = time_total + WORD_W'(cost_sel);

  // word merge into the block
  always_comb begin
    new_buf = blk_buf;
    if (op_wr) new_buf[cur_off*WORD_W +: WORD_W] = wdata;
  end

  // transaction capture and block buffer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_wr   <= kind;
      cur_blk <= address[ADDR_W-1:BLK_LSB];
      cur_off <= address[BLK_LSB-1:WORD_LSB];
      wdata   <= write_word;
    end
    priority if (cmd.l2_rdwait) blk_buf <= l2_q;
    else if (cmd.req_wb || cmd.req_fill || cmd.l2_chk) begin
      if (!cmd.l2_chk && !cmd.l2_op) blk_buf <= l1_q[BLOCK_BITS-1:0];
    end
    else if (status.l1_hit && !cmd.finish && !cmd.capture) blk_buf <= l1_q[BLOCK_BITS-1:0];
    if (cmd.req_wb) begin
      req_blk <= {l1q_tag, cur_idx};
      req_wr  <= 1'b1;
    end else if (cmd.req_fill) begin
      req_blk <= cur_blk;
      req_wr  <= 1'b0;
    end
    if (cmd.l2_chk) begin
      meta_w    <= meta_q;
      way       <= way_sel;
      l2hit_reg <= status.l2_hit;
    end else if (cmd.fill) begin
      meta_w.tag[way]   <= req_tag;
      meta_w.valid[way] <= 1'b1;
      meta_w.dirty[way] <= 1'b0;
    end
  end

  // L1 row store
  always_ff @(posedge clk) begin
    if (cmd.capture) l1_q <= l1_mem[in_idx];
    if (cmd.finish)  l1_mem[cur_idx] <= {cur_tag, new_buf};
  end

  // L2 set rows, cleared after reset
  always_ff @(posedge clk) begin
    if (cmd.meta_rd) meta_q <= meta_mem[req_set];
    if (cmd.clear)      meta_mem[clr_cnt[L2_SET_W-1:0]] <= '0;
    else if (cmd.l2_op) meta_mem[req_set] <= meta_nxt;
  end

  // L2 block store
  always_ff @(posedge clk) begin
    if (cmd.vict_rd || (cmd.l2_op && !req_wr)) l2_q <= l2_mem[{req_set, way}];
    if (cmd.fill)                  l2_mem[{req_set, way}] <= back_q;
    else if (cmd.l2_op && req_wr)  l2_mem[{req_set, way}] <= blk_buf;
  end

  // backing store, cleared after reset
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) back_q <= back_mem[req_blk[MEM_BLK_W-1:0]];
    if (cmd.clear) back_mem[clr_cnt] <= '0;
    else if (cmd.vict_wb)
      back_mem[MEM_BLK_W'({meta_w.tag[way], req_set})] <= l2_q;
  end

  // control state: valid bits, costs, time, clear counter, results
  always_ff @(posedge clk) begin
    if (rst) begin
      l1_valid     <= '0;
      l1_dirty     <= '0;
      time_total   <= '0;
      clr_cnt      <= '0;
      l1hit_reg    <= 1'b0;
      done         <= 1'b0;
      read_word    <= '0;
      l1_hit       <= 1'b0;
      l2_hit       <= 1'b0;
      range_error  <= 1'b0;
      elapsed_time <= '0;
      for (int i = 0; i < CFG_COUNT; i++) cfg_regs[i] <= CFG_RESET[i];
    end else begin
      done <= 1'b0;
      if (cfg_valid && (cfg_index < CFG_IDX_W'(CFG_COUNT))) begin
        cfg_regs[cfg_index] <= cfg_data;
      end
      if (cmd.clear) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.capture) l1hit_reg <= 1'b0;
      else if (status.l1_hit && !cmd.finish && !busy_any(cmd)) l1hit_reg <= 1'b1;
      if (cmd.vict_wb || cmd.fill || cmd.l2_op) time_total <= time_sum;
      if (cmd.finish) begin
        time_total        <= time_sum;
        l1_valid[cur_idx] <= 1'b1;
        l1_dirty[cur_idx] <= op_wr || (l1hit_reg && l1_dirty[cur_idx]);
        done              <= 1'b1;
        read_word         <= op_wr ? '0 : blk_buf[cur_off*WORD_W +: WORD_W];
        l1_hit            <= l1hit_reg;
        l2_hit            <= l1hit_reg ? 1'b0 : l2hit_reg;
        range_error       <= 1'b0;
        elapsed_time      <= time_sum;
      end else if (cmd.err_out) begin
        done         <= 1'b1;
        read_word    <= '0;
        l1_hit       <= 1'b0;
        l2_hit       <= 1'b0;
        range_error  <= 1'b1;
        elapsed_time <= time_total;
      end
    end
  end

endmodule

### hdl/two_level_writeback_cache.sv
// one transaction at a time; the next start is taken in the cycle done is
// shown, and the receiver cannot stall the done strobe
// reset: synchronous; after rst a clear pass over all backing memory blocks
// and L2 set rows runs with busy high
module two_level_writeback_cache import tlc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 kind,
  input  logic [ADDR_W-1:0]    address,
  input  logic [WORD_W-1:0]    write_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COST_W-1:0]    cfg_data,
  output logic                 done,
  output logic [WORD_W-1:0]    read_word,
  output logic                 l1_hit,
  output logic                 l2_hit,
  output logic                 range_error,
  output logic [WORD_W-1:0]    elapsed_time
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  // controller
  tlc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // datapath
  tlc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .kind         (kind),
    .address      (address),
    .write_word   (write_word),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .done         (done),
    .read_word    (read_word),
    .l1_hit       (l1_hit),
    .l2_hit       (l2_hit),
    .range_error  (range_error),
    .elapsed_time (elapsed_time)
  );

endmodule

### hdl/tlc_checker.sv
// port-level checks of the cache, bound to the top level
module tlc_checker import tlc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [WORD_W-1:0] read_word,
  input logic              l1_hit,
  input logic              l2_hit,
  input logic              range_error
);

  // an accepted transaction either keeps the block busy or completes at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transaction neither busy nor done");

  // results appear only once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // a range error reports no data and no hits
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (done && range_error) |-> (read_word == '0 && !l1_hit && !l2_hit))
    else $error("range error with data or hit");

  // an L1 hit never reports an L2 hit
  a_hit_excl: assert property (@(posedge clk) disable iff (rst)
    (done && l1_hit) |-> !l2_hit)
    else $error("l1 and l2 hit together");

endmodule

bind two_level_writeback_cache tlc_checker u_tlc_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .read_word   (read_word),
  .l1_hit      (l1_hit),
  .l2_hit      (l2_hit),
  .range_error (range_error)
);
